### src/eav_pkg.sv
// ----------------------------------------------------------------------------
// eav_pkg
// Shared types and constants for the email address validator.
// ----------------------------------------------------------------------------
package eav_pkg;

   localparam int WORD_W        = 64;
   localparam int NUM_WORD_REGS = 5;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_SUFFIX_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SUFFIX_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SUFFIX_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SUFFIX_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SUFFIX_WORD_4 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SUFFIX_COUNT  = 3'd5;

   localparam logic [7:0] CH_AT  = 8'h40;
   localparam logic [7:0] CH_DOT = 8'h2E;

   typedef enum logic [2:0] {
      ST_START,
      ST_LOCAL,
      ST_AT,
      ST_LDOT,
      ST_DOM1,
      ST_DDOT,
      ST_DOMN,
      ST_REJECT
   } scan_state_type;

   typedef struct packed {
      logic              in_domain_label;
      logic              label_ok;
      logic [WORD_W-1:0] label_word;
   } scan_view_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
   endfunction

endpackage

### src/eav_scanner.sv
// ----------------------------------------------------------------------------
// eav_scanner
// Address recognizer and last-label buffer, advanced one character per step.
// ----------------------------------------------------------------------------
module eav_scanner #(
   parameter int MAX_SUFFIX_CHARS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            char_code,
   input  logic                  is_final,
   output eav_pkg::scan_view_type view
);
   import eav_pkg::*;

   localparam int BUF_W = 8 * MAX_SUFFIX_CHARS;
   localparam int LEN_W = $clog2(MAX_SUFFIX_CHARS + 1);

   scan_state_type   state_ff, state_in, nxt_state;
   logic [BUF_W-1:0] buffer_ff, buffer_in, nxt_buffer;
   logic [LEN_W-1:0] len_ff, len_in, nxt_len;
   logic             over_ff, over_in, nxt_over;
   logic [WORD_W-1:0] ext_buffer;
   logic [WORD_W-1:0] packed_word;
   logic              letter, alnum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_START;
         buffer_ff <= '0;
         len_ff    <= '0;
         over_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         buffer_ff <= buffer_in;
         len_ff    <= len_in;
         over_ff   <= over_in;
      end
   end

   always_comb begin
      letter = is_letter(char_code);
      alnum  = is_alnum(char_code);

      case (state_ff)
         ST_START: begin
            nxt_state = letter ? ST_LOCAL : ST_REJECT;
         end
         ST_LOCAL: begin
            if (alnum) nxt_state = ST_LOCAL;
            else if (char_code == CH_AT) nxt_state = ST_AT;
            else if (char_code == CH_DOT) nxt_state = ST_LDOT;
            else nxt_state = ST_REJECT;
         end
         ST_AT: begin
            nxt_state = letter ? ST_DOM1 : ST_REJECT;
         end
         ST_LDOT: begin
            nxt_state = letter ? ST_LOCAL : ST_REJECT;
         end
         ST_DOM1, ST_DOMN: begin
            if (alnum) nxt_state = state_ff;
            else if (char_code == CH_DOT) nxt_state = ST_DDOT;
            else nxt_state = ST_REJECT;
         end
         ST_DDOT: begin
            nxt_state = letter ? ST_DOMN : ST_REJECT;
         end
         default: begin
            nxt_state = ST_REJECT;
         end
      endcase

      nxt_buffer = buffer_ff;
      nxt_len    = len_ff;
      nxt_over   = over_ff;
      if (nxt_state != ST_REJECT) begin
         if (char_code == CH_DOT || char_code == CH_AT) begin
            nxt_buffer = '0;
            nxt_len    = '0;
            nxt_over   = 1'b0;
         end else if (len_ff < LEN_W'(MAX_SUFFIX_CHARS)) begin
            nxt_buffer = {buffer_ff[BUF_W-9:0], char_code};
            nxt_len    = len_ff + 1'b1;
         end else begin
            nxt_over = 1'b1;
         end
      end

      // left-align the held label into a full word
      ext_buffer  = WORD_W'(nxt_buffer);
      packed_word = '0;
      for (int k = 1; k <= MAX_SUFFIX_CHARS; k++) begin
         if (nxt_len == LEN_W'(k)) packed_word = ext_buffer << (8 * (8 - k));
      end

      view.in_domain_label = (nxt_state == ST_DOMN);
      view.label_ok        = (nxt_len != '0) && !nxt_over;
      view.label_word      = packed_word;

      state_in  = state_ff;
      buffer_in = buffer_ff;
      len_in    = len_ff;
      over_in   = over_ff;
      if (step) begin
         if (is_final) begin
            state_in  = ST_START;
            buffer_in = '0;
            len_in    = '0;
            over_in   = 1'b0;
         end else begin
            state_in  = nxt_state;
            buffer_in = nxt_buffer;
            len_in    = nxt_len;
            over_in   = nxt_over;
         end
      end
   end

   a_restart_after_final: assert property (@(posedge clock) disable iff (reset)
      step && is_final |=> state_ff == ST_START && len_ff == '0 && !over_ff)
      else $error("scanner did not restart after final transaction");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> len_ff == LEN_W'(MAX_SUFFIX_CHARS))
      else $error("label overflow flagged with a partly filled buffer");

endmodule

### src/email_address_validator.sv
// ----------------------------------------------------------------------------
// email_address_validator
// Streams an address one character per transaction and answers once per
// address whether it is well formed and ends in a configured suffix word.
// ----------------------------------------------------------------------------
// One character is taken every cycle while no final character waits on the
// result register. A character passes through an input register, from which
// the recognizer state and label buffer step and, on the final character, the
// suffix compares load the result register that drives is_valid. Only a final
// character waits on a full, stalled result register; other characters keep
// flowing. Suffix words and count are to be written only while no address is
// in flight; the block itself does not enforce it.
module email_address_validator #(
   parameter int MAX_SUFFIX_CHARS = 8,
   parameter int NUM_SUFFIXES     = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_char_code,
   input  logic                               req_is_final,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_is_valid,
   input  logic                               csr_write_enable,
   input  logic [eav_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [eav_pkg::WORD_W-1:0]         csr_data
);
   import eav_pkg::*;

   localparam int NUM_ACTIVE = (NUM_SUFFIXES < NUM_WORD_REGS) ? NUM_SUFFIXES : NUM_WORD_REGS;

   logic [WORD_W-1:0] suffix_word_ff [NUM_WORD_REGS];
   logic [2:0]        suffix_count_ff;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_char_ff;
   logic              in_final_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_is_valid_ff, rsp_is_valid_in;

   logic              accept, step, out_free, hit, is_valid_in;
   scan_view_type     view;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_final_ff || out_free);
   assign req_stall = in_valid_ff && !step;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORD_REGS; i++) suffix_word_ff[i] <= '0;
         suffix_count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SUFFIX_WORD_0: suffix_word_ff[0] <= csr_data;
            REG_SUFFIX_WORD_1: suffix_word_ff[1] <= csr_data;
            REG_SUFFIX_WORD_2: suffix_word_ff[2] <= csr_data;
            REG_SUFFIX_WORD_3: suffix_word_ff[3] <= csr_data;
            REG_SUFFIX_WORD_4: suffix_word_ff[4] <= csr_data;
            REG_SUFFIX_COUNT:  suffix_count_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign in_valid_in = accept || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff  <= req_char_code;
         in_final_ff <= req_is_final;
      end
   end

   eav_scanner #(
      .MAX_SUFFIX_CHARS(MAX_SUFFIX_CHARS)
   ) u_scanner (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_code(in_char_ff),
      .is_final (in_final_ff),
      .view     (view)
   );

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < NUM_ACTIVE; i++) begin
         if (3'(i) < suffix_count_ff && suffix_word_ff[i] == view.label_word) hit = 1'b1;
      end
      is_valid_in = view.in_domain_label && view.label_ok && hit;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_valid_in = rsp_is_valid_ff;
      if (step && in_final_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_is_valid_in = is_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_valid_ff <= rsp_is_valid_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      !$past(rsp_valid_ff) && rsp_valid_ff |-> $past(step && in_final_ff))
      else $error("response raised without a final transaction");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step && in_final_ff |-> !rsp_valid_ff || !rsp_stall)
      else $error("final transaction stepped over a pending response");

   a_match_needs_count: assert property (@(posedge clock) disable iff (reset)
      step && in_final_ff && is_valid_in |-> suffix_count_ff != 3'd0)
      else $error("address matched with no suffix words in use");

endmodule
